@@ rtl/core/pf_pkg.sv @@
// shared types, constants and cell arithmetic for the playfair encryptor
package pf_pkg;

  localparam int LETTER_W    = 5;
  localparam int CELL_W      = 5;
  localparam int NUM_LETTERS = 26;
  localparam int GRID_CELLS  = 25;

  localparam logic [LETTER_W-1:0] LETTER_Q    = 5'd16;
  localparam logic [LETTER_W-1:0] LETTER_X    = 5'd23;
  localparam logic [LETTER_W-1:0] LETTER_LAST = 5'd25;
  localparam logic [CELL_W-1:0]   CELLS_FULL  = 5'd25;

  typedef enum logic [1:0] {
    FUNC_KEY   = 2'd0,
    FUNC_PLAIN = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS,
    ST_GRID,
    ST_EMIT
  } state_t;

  // one memory access slot: a write port and two read ports
  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [CELL_W-1:0] raddr0;
    logic [CELL_W-1:0] raddr1;
  } mem_req_t;

  // row of a cell, cell / 5 through a reciprocal multiply (exact for 0..24)
  function automatic logic [2:0] cell_row(input logic [CELL_W-1:0] cell_idx);
    logic [9:0] prod;
    prod = {5'd0, cell_idx} * 10'd13;
    return prod[8:6];
  endfunction

  function automatic logic [2:0] cell_col(input logic [CELL_W-1:0] cell_idx);
    logic [2:0]        r;
    logic [CELL_W-1:0] base;
    r    = cell_row(cell_idx);
    base = {r, 2'b00} + {2'b00, r};
    return 3'(cell_idx - base);
  endfunction

  function automatic logic [CELL_W-1:0] make_cell(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
  endfunction

endpackage

@@ rtl/core/playfair_digraph_encryptor.sv @@
// top level of the playfair digraph encryptor
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   in_func, in_letter
//  out      out  out_valid/out_stall out_first_letter, out_second_letter, out_last
//
// a key letter is placed from idle; a plaintext letter or flush takes the position step,
// and with a result the position read, grid read and output load; each memory read is registered
// the first plaintext letter after a key first fills the grid, one step per letter a..z
// reset (rst_n low, synchronous) clears the used marks, fill count and waiting
// letter; grid and position memories are not cleared
// a stalled result holds in the output register and the emit step, stalling input
module playfair_digraph_encryptor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [pf_pkg::LETTER_W-1:0] in_letter,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pf_pkg::LETTER_W-1:0] out_first_letter,
  output logic [pf_pkg::LETTER_W-1:0] out_second_letter,
  output logic                        out_last
);

  import pf_pkg::*;

  // memory request bundles from the sequencer
  mem_req_t            grid_req;
  mem_req_t            pos_req;
  logic [LETTER_W-1:0] grid_rdata0, grid_rdata1;
  logic [CELL_W-1:0]   pos_rdata0, pos_rdata1;

  // control: placement, grid completion, pairing, output register
  pf_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_letter         (in_letter),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_first_letter  (out_first_letter),
    .out_second_letter (out_second_letter),
    .out_last          (out_last),
    .grid_req          (grid_req),
    .pos_req           (pos_req),
    .grid_rdata0       (grid_rdata0),
    .grid_rdata1       (grid_rdata1),
    .pos_rdata0        (pos_rdata0),
    .pos_rdata1        (pos_rdata1)
  );

  // letter held in each cell, row*5+col
  pf_ram #(
    .DEPTH (GRID_CELLS),
    .DW    (LETTER_W)
  ) u_grid (
    .clk    (clk),
    .we     (grid_req.we),
    .waddr  (grid_req.waddr),
    .wdata  (grid_req.wdata),
    .re     (grid_req.re),
    .raddr0 (grid_req.raddr0),
    .raddr1 (grid_req.raddr1),
    .rdata0 (grid_rdata0),
    .rdata1 (grid_rdata1)
  );

  // cell of each letter
  pf_ram #(
    .DEPTH (NUM_LETTERS),
    .DW    (CELL_W)
  ) u_pos (
    .clk    (clk),
    .we     (pos_req.we),
    .waddr  (pos_req.waddr),
    .wdata  (pos_req.wdata),
    .re     (pos_req.re),
    .raddr0 (pos_req.raddr0),
    .raddr1 (pos_req.raddr1),
    .rdata0 (pos_rdata0),
    .rdata1 (pos_rdata1)
  );

endmodule

@@ rtl/core/pf_ram.sv @@
// synchronous memory, one write port and two registered read ports
module pf_ram #(
  parameter int DEPTH = pf_pkg::GRID_CELLS,
  parameter int DW    = pf_pkg::LETTER_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

@@ rtl/core/pf_pair_map.sv @@
// maps the two plaintext cells of a pair to their ciphertext cells
module pf_pair_map (
  input  logic [pf_pkg::CELL_W-1:0] pos0,
  input  logic [pf_pkg::CELL_W-1:0] pos1,
  output logic [pf_pkg::CELL_W-1:0] cell0,
  output logic [pf_pkg::CELL_W-1:0] cell1
);

  import pf_pkg::*;

  logic [2:0] r0, c0, r1, c1;

  always_comb begin
    r0 = cell_row(pos0);
    c0 = cell_col(pos0);
    r1 = cell_row(pos1);
    c1 = cell_col(pos1);
    if (r0 == r1) begin
      // same row, shift right
      cell0 = make_cell(r0, wrap_inc(c0));
      cell1 = make_cell(r1, wrap_inc(c1));
    end else if (c0 == c1) begin
      // same column, shift down
      cell0 = make_cell(wrap_inc(r0), c0);
      cell1 = make_cell(wrap_inc(r1), c1);
    end else begin
      // rectangle corners
      cell0 = make_cell(r0, c1);
      cell1 = make_cell(r1, c0);
    end
  end

endmodule

@@ rtl/core/pf_seq.sv @@
// sequencer: key placement, grid completion, pairing and cipher lookups
module pf_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [pf_pkg::LETTER_W-1:0] in_letter,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pf_pkg::LETTER_W-1:0] out_first_letter,
  output logic [pf_pkg::LETTER_W-1:0] out_second_letter,
  output logic                        out_last,
  output pf_pkg::mem_req_t            grid_req,
  output pf_pkg::mem_req_t            pos_req,
  input  logic [pf_pkg::LETTER_W-1:0] grid_rdata0,
  input  logic [pf_pkg::LETTER_W-1:0] grid_rdata1,
  input  logic [pf_pkg::CELL_W-1:0]   pos_rdata0,
  input  logic [pf_pkg::CELL_W-1:0]   pos_rdata1
);

  import pf_pkg::*;

  state_t                state_r, state_nxt;
  logic [NUM_LETTERS-1:0] used_r, used_nxt;
  logic [CELL_W-1:0]     fill_r, fill_nxt;
  logic                  key_done_r, key_done_nxt;
  logic                  pend_r, pend_nxt;
  logic [LETTER_W-1:0]   pend_letter_r, pend_letter_nxt;
  logic [LETTER_W-1:0]   fill_ch_r, fill_ch_nxt;
  logic [1:0]            func_r, func_nxt;
  logic [LETTER_W-1:0]   letter_r, letter_nxt;
  logic                  last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [LETTER_W-1:0]   out_first_r, out_first_nxt;
  logic [LETTER_W-1:0]   out_second_r, out_second_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  place_go;
  logic [LETTER_W-1:0]   place_ch;
  logic [CELL_W-1:0]     cell0, cell1;

  pf_pair_map u_map (
    .pos0  (pos_rdata0),
    .pos1  (pos_rdata1),
    .cell0 (cell0),
    .cell1 (cell1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      key_done_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      key_done_r  <= key_done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_letter_r <= pend_letter_nxt;
    fill_ch_r     <= fill_ch_nxt;
    func_r        <= func_nxt;
    letter_r      <= letter_nxt;
    last_r        <= last_nxt;
    out_first_r   <= out_first_nxt;
    out_second_r  <= out_second_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    used_nxt        = used_r;
    fill_nxt        = fill_r;
    key_done_nxt    = key_done_r;
    pend_nxt        = pend_r;
    pend_letter_nxt = pend_letter_r;
    fill_ch_nxt     = fill_ch_r;
    func_nxt        = func_r;
    letter_nxt      = letter_r;
    last_nxt        = last_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_first_nxt   = out_first_r;
    out_second_nxt  = out_second_r;
    out_last_nxt    = out_last_r;
    place_go        = 1'b0;
    place_ch        = in_letter;
    grid_req        = '0;
    pos_req         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          letter_nxt = in_letter;
          case (in_func)
            FUNC_KEY: begin
              if (in_letter <= LETTER_LAST) begin
                // key after plaintext starts over
                if (key_done_r) begin
                  used_nxt     = '0;
                  fill_nxt     = '0;
                  key_done_nxt = 1'b0;
                  pend_nxt     = 1'b0;
                end
                place_go = 1'b1;
              end
            end
            FUNC_PLAIN: begin
              if (in_letter <= LETTER_LAST) begin
                fill_ch_nxt = '0;
                state_nxt   = key_done_r ? ST_POS : ST_FILL;
              end
            end
            FUNC_FLUSH: state_nxt = ST_POS;
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        place_ch = fill_ch_r;
        place_go = 1'b1;
        if (fill_ch_r == LETTER_LAST) begin
          key_done_nxt = 1'b1;
          state_nxt    = ST_POS;
        end else begin
          fill_ch_nxt = fill_ch_r + 5'd1;
        end
      end
      ST_POS: begin
        state_nxt = ST_IDLE;
        if (func_r == FUNC_PLAIN) begin
          if (letter_r != LETTER_Q) begin
            if (!pend_r) begin
              pend_nxt        = 1'b1;
              pend_letter_nxt = letter_r;
            end else begin
              pos_req.re     = 1'b1;
              pos_req.raddr0 = pend_letter_r;
              // doubled letter pairs with x and stays waiting
              pos_req.raddr1 = (letter_r == pend_letter_r) ? LETTER_X : letter_r;
              pend_nxt       = (letter_r == pend_letter_r);
              last_nxt       = 1'b0;
              state_nxt      = ST_GRID;
            end
          end
        end else if (pend_r) begin
          pos_req.re     = 1'b1;
          pos_req.raddr0 = pend_letter_r;
          pos_req.raddr1 = LETTER_X;
          pend_nxt       = 1'b0;
          last_nxt       = 1'b1;
          state_nxt      = ST_GRID;
        end
      end
      ST_GRID: begin
        grid_req.re     = 1'b1;
        grid_req.raddr0 = cell0;
        grid_req.raddr1 = cell1;
        state_nxt       = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = grid_rdata0;
          out_second_nxt = grid_rdata1;
          out_last_nxt   = last_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // place one letter in the next free cell
    if (place_go && place_ch != LETTER_Q && !used_nxt[place_ch] && fill_nxt < CELLS_FULL) begin
      grid_req.we       = 1'b1;
      grid_req.waddr    = fill_nxt;
      grid_req.wdata    = place_ch;
      pos_req.we        = 1'b1;
      pos_req.waddr     = place_ch;
      pos_req.wdata     = fill_nxt;
      used_nxt[place_ch] = 1'b1;
      fill_nxt          = fill_nxt + 5'd1;
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_first_letter  = out_first_r;
  assign out_second_letter = out_second_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  a_grid_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    grid_req.re |-> key_done_r)
    else $error("grid read before grid complete");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CELLS_FULL)
    else $error("fill count past grid size");

  a_pend_needs_grid: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> key_done_r)
    else $error("waiting letter without a complete grid");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && (!out_valid_r || !out_stall)) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded from emit");

  a_pos_to_grid: assert property (@(posedge clk) disable iff (!rst_n)
    pos_req.re |=> grid_req.re)
    else $error("position read not followed by grid read");
`endif

endmodule
